### design/hbida_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hbida_pkg
// Shared types, constants and helpers of the hierarchical bitmap ID allocator.
// ============================================================================
package hbida_pkg;

    localparam int BYTE_W    = 8;
    localparam int ID_W      = 12;
    localparam int FAN_SHIFT = 3;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

    // request codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DN_RD,
        S_DN_EV,
        S_UP_RD,
        S_UP_EV,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;   // write zero at the clear pointer, advance it
        logic ld_alloc;   // start a walk down from the root
        logic ld_rel;     // start a walk up from the given leaf
        logic up_sel;     // address the parent byte of the current path
        logic adv_dn;     // take lowest clear bit, descend one level
        logic wr_up;      // write back the modified byte, climb one level
        logic set_full;   // answer pool full
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;   // clear pointer at the last entry
        logic in_range;   // release index inside the pool
        logic lvl_zero;   // walk is at the root level
        logic lvl_last;   // walk is at the leaf level
        logic root_full;  // byte read is all ones
        logic up_more;    // walk up must continue
    } t_sts;

    // position of the lowest clear bit, zero when the byte is full
    function automatic logic [FAN_SHIFT-1:0] lowest_clear(input logic [BYTE_W-1:0] b);
        logic [FAN_SHIFT-1:0] pos;
        pos = '0;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (!b[k]) begin
                pos = FAN_SHIFT'(k);
            end
        end
        return pos;
    endfunction

endpackage

### design/hbida_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// hbida_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module hbida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 585
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/hbida_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// hbida_ctrl
// Sequencer: clear pass, walk down for allocate, walk up for the update.
// ============================================================================
module hbida_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_action,
    input  hbida_pkg::t_sts i_sts,
    output hbida_pkg::t_cmd o_cmd,
    output logic            o_busy,
    output logic            o_done
);
    import hbida_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_RELEASE) begin
                        n_state = i_sts.in_range ? S_UP_RD : S_DONE;
                    end else begin
                        n_state = S_DN_RD;
                    end
                end
            end
            S_DN_RD: n_state = S_DN_EV;
            S_DN_EV: begin
                if (i_sts.lvl_zero && i_sts.root_full) n_state = S_DONE;
                else if (i_sts.lvl_last)              n_state = S_UP_RD;
                else                                  n_state = S_DN_RD;
            end
            S_UP_RD: n_state = S_UP_EV;
            S_UP_EV: n_state = i_sts.up_more ? S_UP_RD : S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_RELEASE) o_cmd.ld_rel   = 1'b1;
                    else                         o_cmd.ld_alloc = 1'b1;
                end
            end
            S_DN_EV: begin
                if (i_sts.lvl_zero && i_sts.root_full) o_cmd.set_full = 1'b1;
                else                                  o_cmd.adv_dn   = 1'b1;
            end
            S_UP_RD: o_cmd.up_sel = 1'b1;
            S_UP_EV: begin
                o_cmd.up_sel = 1'b1;
                o_cmd.wr_up  = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

### design/hbida_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// hbida_dp
// Datapath: tree byte store, walk registers (path, level base, level), result.
// ============================================================================
module hbida_dp #(
    parameter int LEVELS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hbida_pkg::t_cmd               i_cmd,
    input  logic [hbida_pkg::ID_W-1:0]    i_index,
    output hbida_pkg::t_sts               o_sts,
    output logic [hbida_pkg::ID_W-1:0]    o_id,
    output logic                          o_status
);
    import hbida_pkg::*;

    localparam int PW       = FAN_SHIFT * LEVELS;
    localparam int DEPTH    = ((1 << (FAN_SHIFT * LEVELS)) - 1) / 7;
    localparam int LEAF_OFF = ((1 << (FAN_SHIFT * (LEVELS - 1))) - 1) / 7;
    localparam int RAM_AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [PW-1:0]        r_path;
    logic [PW-1:0]        r_base;
    logic [LW-1:0]        r_lvl;
    logic                 r_rel;
    logic [RAM_AW-1:0]    r_clr;
    logic [ID_W-1:0]      r_id;
    logic                 r_status;

    logic [PW-1:0]        w_addr;
    logic [BYTE_W-1:0]    w_q;
    logic [BYTE_W-1:0]    w_mask;
    logic [BYTE_W-1:0]    w_new;
    logic [FAN_SHIFT-1:0] w_lc;
    logic [PW-1:0]        w_path_dn;
    logic [PW-1:0]        w_path_init;
    logic                 w_in_range;
    logic [ID_W-1:0]      w_id_dn;
    logic                 w_we;
    logic [RAM_AW-1:0]    w_waddr;
    logic [BYTE_W-1:0]    w_wdata;

    // byte address: current prefix going down, parent prefix going up
    assign w_addr = i_cmd.up_sel ? (r_base + (r_path >> FAN_SHIFT)) : (r_base + r_path);

    // byte update and lowest free child
    assign w_mask    = BYTE_W'(1) << r_path[FAN_SHIFT-1:0];
    assign w_new     = r_rel ? (w_q & ~w_mask) : (w_q | w_mask);
    assign w_lc      = lowest_clear(w_q);
    assign w_path_dn = (r_path << FAN_SHIFT) | PW'(w_lc);

    // index / id width adaptation
    generate
        if (PW >= ID_W) begin : g_wide
            assign w_in_range  = 1'b1;
            assign w_path_init = PW'(i_index);
            assign w_id_dn     = w_path_dn[ID_W-1:0];
        end else begin : g_narrow
            assign w_in_range  = ((i_index >> PW) == '0);
            assign w_path_init = i_index[PW-1:0];
            assign w_id_dn     = ID_W'(w_path_dn);
        end
    endgenerate

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_alloc) begin
            r_path <= '0;
            r_base <= '0;
            r_lvl  <= '0;
            r_rel  <= 1'b0;
        end else if (i_cmd.ld_rel) begin
            r_path <= w_path_init;
            r_base <= PW'(LEAF_OFF);
            r_lvl  <= LW'(LEVELS - 1);
            r_rel  <= 1'b1;
        end else if (i_cmd.adv_dn) begin
            r_path <= w_path_dn;
            if (!o_sts.lvl_last) begin
                r_base <= (r_base << FAN_SHIFT) + PW'(1);
                r_lvl  <= r_lvl + LW'(1);
            end
        end else if (i_cmd.wr_up) begin
            r_path <= r_path >> FAN_SHIFT;
            r_base <= (r_base - PW'(1)) >> FAN_SHIFT;
            r_lvl  <= r_lvl - LW'(1);
        end
    end

    // clear pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step && !o_sts.clr_done) begin
            r_clr <= r_clr + RAM_AW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id     <= '0;
            r_status <= 1'b0;
        end else if (i_cmd.ld_alloc || i_cmd.ld_rel) begin
            r_id     <= '0;
            r_status <= 1'b0;
        end else if (i_cmd.set_full) begin
            r_status <= 1'b1;
        end else if (i_cmd.adv_dn && o_sts.lvl_last) begin
            r_id <= w_id_dn;
        end
    end

    // tree store
    assign w_we    = i_cmd.clr_step || i_cmd.wr_up;
    assign w_waddr = i_cmd.clr_step ? r_clr : w_addr[RAM_AW-1:0];
    assign w_wdata = i_cmd.clr_step ? '0 : w_new;

    hbida_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr[RAM_AW-1:0]),
        .o_rdata (w_q)
    );

    // status
    assign o_sts.clr_done  = (r_clr == RAM_AW'(DEPTH - 1));
    assign o_sts.in_range  = w_in_range;
    assign o_sts.lvl_zero  = (r_lvl == '0);
    assign o_sts.lvl_last  = (r_lvl == LW'(LEVELS - 1));
    assign o_sts.root_full = (w_q == FULL_BYTE);
    assign o_sts.up_more   = (r_lvl != '0) && (r_rel || (w_new == FULL_BYTE));

    assign o_id     = r_id;
    assign o_status = r_status;

endmodule

### design/hierarchical_bitmap_id_allocator_unit.sv
`timescale 1ns / 1ps
// Walk: each tree level costs a read and an evaluate state. An allocate walks down from
//   the root, then back up updating 1..LEVELS levels; a release walks up from the leaf.
//   A full pool stops an allocate at the root; a release beyond the pool skips the walk.
// Requests are taken one at a time; busy drops in the cycle after o_done.
// Reset: a clear pass zeroes the (8^LEVELS-1)/7 byte store, one byte a cycle (585 at
//   LEVELS = 4), busy high meanwhile. Results cannot be stalled by the receiver.
// ============================================================================
// hierarchical_bitmap_id_allocator_unit
// Lowest-free-ID allocator kept as an 8-ary tree of bitmap bytes in one RAM.
// ============================================================================
module hierarchical_bitmap_id_allocator_unit #(
    parameter int LEVELS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [hbida_pkg::ID_W-1:0]    i_index,
    output logic                          o_done,
    output logic [hbida_pkg::ID_W-1:0]    o_id,
    output logic                          o_status
);
    import hbida_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    hbida_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // store and walk datapath
    hbida_dp #(
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_index  (i_index),
        .o_sts    (w_sts),
        .o_id     (o_id),
        .o_status (o_status)
    );

endmodule

### design/hbida_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// hbida_checker
// Port-level checks of the allocator's request/result sequencing.
// ============================================================================
module hbida_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [hbida_pkg::ID_W-1:0]  o_id,
    input logic                        o_status
);

    // reset always starts the clear pass
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    // an accepted request keeps the unit busy
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after transfer");

    // result only while busy, then back to idle
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result outside a request");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("not idle after result");

    // pool full answers id zero
    a_full_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_id == '0))
        else $error("nonzero id on full");

endmodule

bind hierarchical_bitmap_id_allocator_unit hbida_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_id     (o_id),
    .o_status (o_status)
);
